// ----- hw/rtl/cubic_bezier_segmenter_unit_assert.svh -----
// Assertion macros for the cubic Bezier segmenter checker.
// Needs clk and rst_n in the scope where the macros are used.
`ifndef CUBIC_BEZIER_SEGMENTER_UNIT_ASSERT_SVH
`define CUBIC_BEZIER_SEGMENTER_UNIT_ASSERT_SVH

// Same-cycle implication, off during reset.
`define CBS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define CBS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/cbs_pkg.sv -----
// Package for the cubic Bezier segmenter: widths, sequencer states,
// divider request/response structs and saturation helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cbs_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int FRAC_BITS    = 16;

    localparam int COORD_W = 32;
    localparam int SEG_W   = 31;
    localparam int PT_W    = 33;
    localparam int LEG_W   = 34;
    localparam int MAG_W   = 31;
    localparam int MUL_W   = 33;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int SQ_W    = 63;
    localparam int LEN_W   = 32;
    localparam int NACC_W  = SEG_W + 7;
    localparam int N_W     = $clog2(MAX_SEGMENTS + 1);
    localparam int SQ_W13  = 2 * N_W - 1;
    localparam int WGT_W   = 18;
    localparam int ACC_W   = 54;
    localparam int DIV_NW  = 53;
    localparam int DIV_DW  = 19;
    localparam int DIV_CW  = $clog2(DIV_NW);
    localparam int RES_W   = 37;

    localparam logic [SEG_W-1:0] SEG_RESET = SEG_W'(1 << FRAC_BITS);

    localparam logic [1:0] CRD_X = 2'd0;
    localparam logic [1:0] CRD_Y = 2'd1;
    localparam logic [1:0] CRD_Z = 2'd2;

    localparam logic [1:0] LEG_FIRST = 2'd0;
    localparam logic [1:0] LEG_MID   = 2'd1;
    localparam logic [1:0] LEG_LAST  = 2'd2;

    localparam logic [1:0] WORDS_BOTH = 2'b11;
    localparam logic [1:0] WORDS_NONE = 2'b00;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LEG,
        S_SQA,
        S_SQB,
        S_SQC,
        S_SQRT,
        S_NCNT,
        S_N3A,
        S_N3B,
        S_N3C,
        S_WGT,
        S_ACC,
        S_DIVST,
        S_DIVGO,
        S_DIVW,
        S_OUT
    } cbs_state_t;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } cbs_div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quotient;
        logic              rem_nz;
    } cbs_div_rsp_t;

    function automatic logic [MAG_W-1:0] abs_sat(input logic signed [LEG_W-1:0] v);
        logic [LEG_W-1:0] mag;
        mag = v[LEG_W-1] ? LEG_W'(-v) : LEG_W'(v);
        return (mag > LEG_W'(34'h07FFFFFFF)) ? {MAG_W{1'b1}} : mag[MAG_W-1:0];
    endfunction

    function automatic logic [COORD_W-1:0] sat32(input logic signed [RES_W-1:0] v);
        logic signed [RES_W-1:0] hi;
        logic signed [RES_W-1:0] lo;
        hi = RES_W'(64'sh7FFFFFFF);
        lo = -RES_W'(64'sh80000000);
        if (v > hi)
        begin
            return 32'h7FFFFFFF;
        end
        else if (v < lo)
        begin
            return 32'h80000000;
        end
        return v[COORD_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/cbs_mul.sv -----
// Shared signed multiplier of the segmenter with registered product.
// Depends on cbs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cbs_mul (
    input  wire logic                               clk,
    input  wire logic signed [cbs_pkg::MUL_W-1:0]   a,
    input  wire logic signed [cbs_pkg::MUL_W-1:0]   b,
    output logic signed [cbs_pkg::PROD_W-1:0]       prod
);
    import cbs_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/cbs_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on cbs_pkg (request/response structs).
`timescale 1ns / 1ps
`default_nettype none
module cbs_div (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cbs_pkg::cbs_div_req_t req,
    output cbs_pkg::cbs_div_rsp_t      rsp
);
    import cbs_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic [DIV_NW-1:0] quo_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_DW-1:0] dvs_reg;
    logic [DIV_DW:0]   trial;
    logic [DIV_DW:0]   diff;
    logic              ge;

    assign trial = {rem_reg, quo_reg[DIV_NW-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CW'(DIV_NW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_NW-2:0], ge};
            rem_reg <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;
    assign rsp.rem_nz   = (rem_reg != '0);

endmodule
`default_nettype wire

// ----- hw/rtl/cubic_bezier_segmenter_unit.sv -----
// Top level of the cubic Bezier segmenter: sequencer, datapath registers.
// Depends on cbs_pkg, cbs_mul and cbs_div.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+------------------------------------
//   cfg      | cfg_wr_en                | cfg_wr_data (segment length)
//   in       | in_valid / in_stall      | start_*, target_*, offsets, flags
//   out      | out_valid / out_stall    | point_x/y/z, status, last
//
// One move first runs the three control-polygon legs (32-step square root
// each), then the segment count, then each point in turn: each of X, Y, Z
// goes through the bit-serial divider, which sets the pace. A missing-word
// move presents its error result in the cycle after it is taken. Reset is
// asynchronous; it clears the sequencer, segment length (to 1.0) and the
// stored P/Q. in_stall stays high from a transfer in until the last point
// has been transferred out; an out_stall simply holds the current point.
`timescale 1ns / 1ps
`default_nettype none
module cubic_bezier_segmenter_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wr_en,
    input  wire logic [cbs_pkg::SEG_W-1:0]           cfg_wr_data,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic signed [cbs_pkg::COORD_W-1:0]  start_x,
    input  wire logic signed [cbs_pkg::COORD_W-1:0]  start_y,
    input  wire logic signed [cbs_pkg::COORD_W-1:0]  start_z,
    input  wire logic signed [cbs_pkg::COORD_W-1:0]  target_x,
    input  wire logic signed [cbs_pkg::COORD_W-1:0]  target_y,
    input  wire logic signed [cbs_pkg::COORD_W-1:0]  target_z,
    input  wire logic signed [cbs_pkg::COORD_W-1:0]  i_off,
    input  wire logic signed [cbs_pkg::COORD_W-1:0]  j_off,
    input  wire logic signed [cbs_pkg::COORD_W-1:0]  p_off,
    input  wire logic signed [cbs_pkg::COORD_W-1:0]  q_off,
    input  wire logic [1:0]                          ij_words,
    input  wire logic                                chained,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic signed [cbs_pkg::COORD_W-1:0]       point_x,
    output logic signed [cbs_pkg::COORD_W-1:0]       point_y,
    output logic signed [cbs_pkg::COORD_W-1:0]       point_z,
    output logic                                     status,
    output logic                                     last
);
    import cbs_pkg::*;

    // Sequencer
    cbs_state_t state_reg, state_next;
    logic [1:0] leg_reg;
    logic [1:0] crd_reg;
    logic [2:0] op_reg;
    logic [4:0] it_reg;

    // Configuration and carried state
    logic [SEG_W-1:0]          seg_reg;
    logic signed [COORD_W-1:0] prev_p_reg;
    logic signed [COORD_W-1:0] prev_q_reg;

    // Move operands
    logic signed [COORD_W-1:0] sx_reg, sy_reg, sz_reg, tx_reg, ty_reg, tz_reg;
    logic signed [PT_W-1:0]    p1x_reg, p1y_reg, p2x_reg, p2y_reg, dz_reg;

    // Leg length and square root
    logic [MAG_W-1:0]  a_reg, b_reg;
    logic [SQ_W-1:0]   sum_reg;
    logic [SQ_W-1:0]   sq_x_reg;
    logic [63:0]       sq_r_reg;
    logic [SQ_W-1:0]   sq_bit_reg;
    logic [LEN_W-1:0]  len_reg;

    // Segment count and weights
    logic [NACC_W-1:0] nacc_reg;
    logic [N_W-1:0]    n_reg, k_reg, m_reg;
    logic [DIV_DW-1:0] n3_reg;
    logic [SQ_W13-1:0] kk_reg, mm_reg;
    logic [WGT_W-1:0]  w0_reg, w3_reg, wkkm_reg, wkmm_reg;

    // Accumulate and divide
    logic signed [ACC_W-1:0] acc_reg;
    logic                    neg_reg;

    // Output register
    logic signed [COORD_W-1:0] px_reg, py_reg, pz_reg;
    logic                      status_reg, last_reg;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    cbs_div_req_t             div_req;
    cbs_div_rsp_t             div_rsp;

    logic                     in_xfer, out_xfer, words_ok;
    logic [SEG_W-1:0]         seg_eff;
    logic signed [LEG_W-1:0]  dx, dy;
    logic [63:0]              sq_trial;
    logic                     sq_take;
    logic [SQ_W-1:0]          sq_x_step;
    logic [63:0]              sq_r_step;
    logic [LEN_W-1:0]         leg_len;
    logic                     ncnt_done;
    logic signed [ACC_W-1:0]  prod_acc;
    logic [DIV_DW-1:0]        den;
    logic signed [ACC_W-1:0]  acc_mag;
    logic signed [RES_W-1:0]  q_s, res_s, res_z;
    logic [COORD_W-1:0]       res_sat;
    logic                     acc_last_op;

    function automatic logic signed [MUL_W-1:0] uext(input logic [31:0] v);
        return $signed({1'b0, v});
    endfunction

    function automatic logic [WGT_W:0] times3(input logic [WGT_W-1:0] w);
        return {w, 1'b0} + {1'b0, w};
    endfunction

    cbs_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    cbs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid && !out_stall;
    assign words_ok = (ij_words == WORDS_BOTH) || (chained && (ij_words == WORDS_NONE));
    assign seg_eff  = (seg_reg == '0) ? SEG_W'(1) : seg_reg;

    // Leg component differences
    always_comb
    begin
        unique case (leg_reg)
            LEG_FIRST:
            begin
                dx = LEG_W'(p1x_reg) - LEG_W'(sx_reg);
                dy = LEG_W'(p1y_reg) - LEG_W'(sy_reg);
            end
            LEG_MID:
            begin
                dx = LEG_W'(p2x_reg) - LEG_W'(p1x_reg);
                dy = LEG_W'(p2y_reg) - LEG_W'(p1y_reg);
            end
            default:
            begin
                dx = LEG_W'(tx_reg) - LEG_W'(p2x_reg);
                dy = LEG_W'(ty_reg) - LEG_W'(p2y_reg);
            end
        endcase
    end

    // One square-root step
    assign sq_trial  = sq_r_reg + {1'b0, sq_bit_reg};
    assign sq_take   = {1'b0, sq_x_reg} >= sq_trial;
    assign sq_x_step = sq_take ? (sq_x_reg - sq_trial[SQ_W-1:0]) : sq_x_reg;
    assign sq_r_step = sq_take ? ((sq_r_reg >> 1) + {1'b0, sq_bit_reg}) : (sq_r_reg >> 1);
    assign leg_len   = sq_r_step[LEN_W-1:0] + LEN_W'(sq_x_step != '0);

    assign ncnt_done = (nacc_reg >= NACC_W'(len_reg)) || (n_reg == N_W'(MAX_SEGMENTS));

    assign prod_acc    = $signed(prod[ACC_W-1:0]);
    assign den         = (crd_reg == CRD_Z) ? DIV_DW'(n_reg) : n3_reg;
    assign acc_mag     = acc_reg[ACC_W-1] ? -acc_reg : acc_reg;
    assign acc_last_op = (crd_reg == CRD_Z) ? (op_reg == 3'd1) : (op_reg == 3'd4);

    // Rounded quotient back to a signed coordinate
    assign q_s     = $signed({2'b00, div_rsp.quotient[RES_W-3:0]});
    assign res_s   = neg_reg ? (-q_s - $signed({{(RES_W-1){1'b0}}, div_rsp.rem_nz})) : q_s;
    assign res_z   = res_s + RES_W'(sz_reg);
    assign res_sat = sat32((crd_reg == CRD_Z) ? res_z : res_s);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = words_ok ? S_LEG : S_OUT;
                end
            end
            S_LEG:   state_next = S_SQA;
            S_SQA:   state_next = S_SQB;
            S_SQB:   state_next = S_SQC;
            S_SQC:   state_next = S_SQRT;
            S_SQRT:
            begin
                if (it_reg == 5'd31)
                begin
                    state_next = (leg_reg == LEG_LAST) ? S_NCNT : S_LEG;
                end
            end
            S_NCNT:
            begin
                if (ncnt_done)
                begin
                    state_next = (n_reg == N_W'(1)) ? S_OUT : S_N3A;
                end
            end
            S_N3A:   state_next = S_N3B;
            S_N3B:   state_next = S_N3C;
            S_N3C:   state_next = S_WGT;
            S_WGT:
            begin
                if (op_reg == 3'd6)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                if (acc_last_op)
                begin
                    state_next = S_DIVST;
                end
            end
            S_DIVST: state_next = S_DIVGO;
            S_DIVGO: state_next = S_DIVW;
            S_DIVW:
            begin
                if (div_rsp.done)
                begin
                    state_next = (crd_reg == CRD_Z) ? S_OUT : S_ACC;
                end
            end
            S_OUT:
            begin
                if (out_xfer)
                begin
                    if (last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (k_reg != n_reg - N_W'(1))
                    begin
                        state_next = S_WGT;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs of the sequencer: handshakes and shared-unit operands
    always_comb
    begin
        in_stall         = (state_reg != S_IDLE);
        out_valid        = (state_reg == S_OUT);
        mul_a            = '0;
        mul_b            = '0;
        div_req.start    = (state_reg == S_DIVGO);
        div_req.dividend = acc_mag[DIV_NW-1:0];
        div_req.divisor  = den;
        unique case (state_reg)
            S_SQA:
            begin
                mul_a = uext(32'(a_reg));
                mul_b = uext(32'(a_reg));
            end
            S_SQB:
            begin
                mul_a = uext(32'(b_reg));
                mul_b = uext(32'(b_reg));
            end
            S_N3A:
            begin
                mul_a = uext(32'(n_reg));
                mul_b = uext(32'(n_reg));
            end
            S_N3B:
            begin
                mul_a = uext(32'(prod[SQ_W13-1:0]));
                mul_b = uext(32'(n_reg));
            end
            S_WGT:
            begin
                unique case (op_reg)
                    3'd0:
                    begin
                        mul_a = uext(32'(k_reg));
                        mul_b = uext(32'(k_reg));
                    end
                    3'd1:
                    begin
                        mul_a = uext(32'(m_reg));
                        mul_b = uext(32'(m_reg));
                    end
                    3'd2:
                    begin
                        mul_a = uext(32'(kk_reg));
                        mul_b = uext(32'(k_reg));
                    end
                    3'd3:
                    begin
                        mul_a = uext(32'(mm_reg));
                        mul_b = uext(32'(m_reg));
                    end
                    3'd4:
                    begin
                        mul_a = uext(32'(kk_reg));
                        mul_b = uext(32'(m_reg));
                    end
                    3'd5:
                    begin
                        mul_a = uext(32'(mm_reg));
                        mul_b = uext(32'(k_reg));
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            S_ACC:
            begin
                if (crd_reg == CRD_Z)
                begin
                    mul_a = dz_reg;
                    mul_b = uext(32'(k_reg));
                end
                else
                begin
                    unique case (op_reg)
                        3'd0:
                        begin
                            mul_a = (crd_reg == CRD_X) ? PT_W'(sx_reg) : PT_W'(sy_reg);
                            mul_b = uext(32'(w0_reg));
                        end
                        3'd1:
                        begin
                            mul_a = (crd_reg == CRD_X) ? p1x_reg : p1y_reg;
                            mul_b = uext(32'(times3(wkmm_reg)));
                        end
                        3'd2:
                        begin
                            mul_a = (crd_reg == CRD_X) ? p2x_reg : p2y_reg;
                            mul_b = uext(32'(times3(wkkm_reg)));
                        end
                        3'd3:
                        begin
                            mul_a = (crd_reg == CRD_X) ? PT_W'(tx_reg) : PT_W'(ty_reg);
                            mul_b = uext(32'(w3_reg));
                        end
                        default:
                        begin
                            mul_a = '0;
                            mul_b = '0;
                        end
                    endcase
                end
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            seg_reg    <= SEG_RESET;
            prev_p_reg <= '0;
            prev_q_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                seg_reg <= cfg_wr_data;
            end
            if (in_xfer && words_ok)
            begin
                prev_p_reg <= p_off;
                prev_q_reg <= q_off;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    // Capture the move; mirror the previous P/Q when I/J are absent.
                    sx_reg  <= start_x;
                    sy_reg  <= start_y;
                    sz_reg  <= start_z;
                    tx_reg  <= target_x;
                    ty_reg  <= target_y;
                    tz_reg  <= target_z;
                    p1x_reg <= PT_W'(start_x) + ((ij_words == WORDS_BOTH) ?
                               PT_W'(i_off) : -PT_W'(prev_p_reg));
                    p1y_reg <= PT_W'(start_y) + ((ij_words == WORDS_BOTH) ?
                               PT_W'(j_off) : -PT_W'(prev_q_reg));
                    p2x_reg <= PT_W'(target_x) + PT_W'(p_off);
                    p2y_reg <= PT_W'(target_y) + PT_W'(q_off);
                    dz_reg  <= PT_W'(target_z) - PT_W'(start_z);
                    leg_reg <= LEG_FIRST;
                    len_reg <= '0;
                    if (!words_ok)
                    begin
                        px_reg     <= '0;
                        py_reg     <= '0;
                        pz_reg     <= '0;
                        status_reg <= 1'b1;
                        last_reg   <= 1'b1;
                    end
                end
            end
            S_LEG:
            begin
                a_reg <= abs_sat(dx);
                b_reg <= abs_sat(dy);
            end
            S_SQB:
            begin
                sum_reg <= {1'b0, prod[SQ_W-2:0]};
            end
            S_SQC:
            begin
                sq_x_reg   <= sum_reg + {1'b0, prod[SQ_W-2:0]};
                sq_r_reg   <= '0;
                sq_bit_reg <= {1'b1, {(SQ_W-1){1'b0}}};
                it_reg     <= '0;
            end
            S_SQRT:
            begin
                sq_x_reg   <= sq_x_step;
                sq_r_reg   <= sq_r_step;
                sq_bit_reg <= sq_bit_reg >> 2;
                it_reg     <= it_reg + 1'b1;
                if (it_reg == 5'd31)
                begin
                    // Keep the longest leg; advance to the next one.
                    if (leg_len > len_reg)
                    begin
                        len_reg <= leg_len;
                    end
                    leg_reg  <= leg_reg + 1'b1;
                    nacc_reg <= NACC_W'(seg_eff);
                    n_reg    <= N_W'(1);
                end
            end
            S_NCNT:
            begin
                if (!ncnt_done)
                begin
                    n_reg    <= n_reg + 1'b1;
                    nacc_reg <= nacc_reg + NACC_W'(seg_eff);
                end
                else if (n_reg == N_W'(1))
                begin
                    px_reg     <= tx_reg;
                    py_reg     <= ty_reg;
                    pz_reg     <= tz_reg;
                    status_reg <= 1'b0;
                    last_reg   <= 1'b1;
                end
            end
            S_N3C:
            begin
                n3_reg <= prod[DIV_DW-1:0];
                k_reg  <= N_W'(1);
                m_reg  <= n_reg - N_W'(1);
                op_reg <= '0;
            end
            S_WGT:
            begin
                op_reg <= op_reg + 1'b1;
                unique case (op_reg)
                    3'd1:    kk_reg   <= prod[SQ_W13-1:0];
                    3'd2:    mm_reg   <= prod[SQ_W13-1:0];
                    3'd3:    w3_reg   <= prod[WGT_W-1:0];
                    3'd4:    w0_reg   <= prod[WGT_W-1:0];
                    3'd5:    wkkm_reg <= prod[WGT_W-1:0];
                    3'd6:
                    begin
                        wkmm_reg <= prod[WGT_W-1:0];
                        op_reg   <= '0;
                        crd_reg  <= CRD_X;
                    end
                    default: ;
                endcase
            end
            S_ACC:
            begin
                op_reg <= op_reg + 1'b1;
                if (op_reg == 3'd1)
                begin
                    acc_reg <= prod_acc;
                end
                else if (op_reg != 3'd0)
                begin
                    acc_reg <= acc_reg + prod_acc;
                end
            end
            S_DIVST:
            begin
                // Bias by half the divisor for round-to-nearest.
                acc_reg <= acc_reg + $signed({{(ACC_W-DIV_DW){1'b0}}, den >> 1});
            end
            S_DIVGO:
            begin
                neg_reg <= acc_reg[ACC_W-1];
            end
            S_DIVW:
            begin
                if (div_rsp.done)
                begin
                    op_reg <= '0;
                    crd_reg <= crd_reg + 1'b1;
                    unique case (crd_reg)
                        CRD_X:   px_reg <= res_sat;
                        CRD_Y:   py_reg <= res_sat;
                        default:
                        begin
                            pz_reg     <= res_sat;
                            status_reg <= 1'b0;
                            last_reg   <= 1'b0;
                        end
                    endcase
                end
            end
            S_OUT:
            begin
                if (out_xfer && !last_reg)
                begin
                    if (k_reg == n_reg - N_W'(1))
                    begin
                        // Close the move on the exact target.
                        px_reg   <= tx_reg;
                        py_reg   <= ty_reg;
                        pz_reg   <= tz_reg;
                        last_reg <= 1'b1;
                    end
                    else
                    begin
                        k_reg  <= k_reg + 1'b1;
                        m_reg  <= m_reg - 1'b1;
                        op_reg <= '0;
                    end
                end
            end
            default: ;
        endcase
    end

    assign point_x = px_reg;
    assign point_y = py_reg;
    assign point_z = pz_reg;
    assign status  = status_reg;
    assign last    = last_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/cbs_check.sv -----
// Port-level checker for the cubic Bezier segmenter, bound to the top level.
// Depends on cbs_pkg and cubic_bezier_segmenter_unit_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "cubic_bezier_segmenter_unit_assert.svh"
module cbs_check (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    input  wire logic                                in_stall,
    input  wire logic                                out_valid,
    input  wire logic                                out_stall,
    input  wire logic signed [cbs_pkg::COORD_W-1:0]  point_x,
    input  wire logic signed [cbs_pkg::COORD_W-1:0]  point_y,
    input  wire logic signed [cbs_pkg::COORD_W-1:0]  point_z,
    input  wire logic                                status,
    input  wire logic                                last
);
    import cbs_pkg::*;

    `CBS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "out_valid dropped")
    `CBS_ASSERT_NOW(a_busy_out, out_valid, in_stall, "input open with a point pending")
    `CBS_ASSERT_NEXT(a_busy_in, in_valid && !in_stall, in_stall, "input open after a transfer")
    `CBS_ASSERT_NOW(a_err_fmt, out_valid && status, last && {point_x, point_y, point_z} == '0, "bad err")
    `CBS_ASSERT_NEXT(a_last_end, out_valid && !out_stall && last, !out_valid, "point after last")

endmodule

bind cubic_bezier_segmenter_unit cbs_check u_check (.*);
`default_nettype wire

// ----- sim/cubic_bezier_segmenter_unit_test.sv -----
// Self-checking bench for the cubic Bezier segmenter: directed moves, then random phases
// under several segment lengths, checked point by point against a built-in predictor.
// Depends on cbs_pkg and cubic_bezier_segmenter_unit.
`timescale 1ns / 1ps
module cubic_bezier_segmenter_unit_test;
    import cbs_pkg::*;

    localparam int IDLE_LIMIT = 30000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_MOVES = 50;
    localparam longint MAG_MAX = 64'd2147483647;

    typedef struct {
        logic signed [COORD_W-1:0] sx, sy, sz, tx, ty, tz, io, jo, po, qo;
        logic [1:0] words;
        logic chained;
    } move_t;

    typedef struct {
        logic signed [COORD_W-1:0] x, y, z;
        logic st, fin;
    } point_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [SEG_W-1:0] cfg_wr_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [COORD_W-1:0] start_x = '0, start_y = '0, start_z = '0;
    logic signed [COORD_W-1:0] target_x = '0, target_y = '0, target_z = '0;
    logic signed [COORD_W-1:0] i_off = '0, j_off = '0, p_off = '0, q_off = '0;
    logic [1:0] ij_words = '0;
    logic chained = 1'b0;
    logic out_valid;
    logic out_stall = 1'b1;
    logic signed [COORD_W-1:0] point_x, point_y, point_z;
    logic status, last;

    int mismatch_count = 0;
    bit idle_on = 1'b1;

    // Count a failure and print one line for it.
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    class PointScoreboard;
        longint unsigned seg_len;
        longint prev_p, prev_q;
        point_t due[$];

        function new();
            seg_len = 64'd65536;
            prev_p = 0;
            prev_q = 0;
        endfunction

        function longint unsigned mag_sat(longint v);
            if (v < 0) v = -v;
            return (v > MAG_MAX) ? MAG_MAX : v;
        endfunction

        function longint unsigned root_ceil(longint unsigned v);
            longint unsigned r, b, x;
            r = 0;
            b = 64'd1 << 62;
            x = v;
            while (b > x) b >>= 2;
            while (b != 0)
            begin
                if (x >= r + b)
                begin
                    x -= r + b;
                    r = (r >> 1) + b;
                end
                else
                begin
                    r >>= 1;
                end
                b >>= 2;
            end
            if (r * r < v) r++;
            return r;
        endfunction

        function longint unsigned leg(longint dx, longint dy);
            longint unsigned a, b;
            a = mag_sat(dx);
            b = mag_sat(dy);
            return root_ceil(a * a + b * b);
        endfunction

        // Nearest, ties toward plus infinity; den is positive.
        function longint round_div(longint num, longint den);
            longint s, q;
            s = num + den / 2;
            q = s / den;
            if ((s % den) != 0 && s < 0) q--;
            return q;
        endfunction

        function longint clamp32(longint v);
            if (v > MAG_MAX) return MAG_MAX;
            if (v < -MAG_MAX - 1) return -MAG_MAX - 1;
            return v;
        endfunction

        function longint blend(longint a, longint b, longint c, longint d,
                               longint k, longint n);
            longint m;
            m = n - k;
            return clamp32(round_div(a * m * m * m + 3 * b * k * m * m
                                     + 3 * c * k * k * m + d * k * k * k, n * n * n));
        endfunction

        function void note_move(move_t mv);
            longint sx, sy, sz, tx, ty, tz, ax, ay, bx, by, n;
            longint unsigned len, l2, seg, nn;
            point_t pt;
            if (!(mv.words == WORDS_BOTH || (mv.chained && mv.words == WORDS_NONE)))
            begin
                pt = '{x: '0, y: '0, z: '0, st: 1'b1, fin: 1'b1};
                due.push_back(pt);
                return;
            end
            sx = mv.sx; sy = mv.sy; sz = mv.sz;
            tx = mv.tx; ty = mv.ty; tz = mv.tz;
            if (mv.words == WORDS_BOTH)
            begin
                ax = sx + longint'(mv.io);
                ay = sy + longint'(mv.jo);
            end
            else
            begin
                ax = sx - prev_p;
                ay = sy - prev_q;
            end
            bx = tx + longint'(mv.po);
            by = ty + longint'(mv.qo);
            len = leg(ax - sx, ay - sy);
            l2 = leg(bx - ax, by - ay);
            if (l2 > len) len = l2;
            l2 = leg(tx - bx, ty - by);
            if (l2 > len) len = l2;
            seg = (seg_len != 0) ? seg_len : 1;
            nn = (len + seg - 1) / seg;
            if (nn < 1) nn = 1;
            if (nn > MAX_SEGMENTS) nn = MAX_SEGMENTS;
            n = nn;
            for (longint k = 1; k < n; k++)
            begin
                pt.x = 32'(blend(sx, ax, bx, tx, k, n));
                pt.y = 32'(blend(sy, ay, by, ty, k, n));
                pt.z = 32'(clamp32(sz + round_div((tz - sz) * k, n)));
                pt.st = 1'b0;
                pt.fin = 1'b0;
                due.push_back(pt);
            end
            pt = '{x: mv.tx, y: mv.ty, z: mv.tz, st: 1'b0, fin: 1'b1};
            due.push_back(pt);
            prev_p = mv.po;
            prev_q = mv.qo;
        endfunction

        task check_point(point_t got);
            point_t want;
            if (due.size() == 0)
            begin
                report_mismatch("point with nothing expected");
                return;
            end
            want = due.pop_front();
            if (got.x !== want.x)
                report_mismatch($sformatf("point_x %0d, want %0d", got.x, want.x));
            if (got.y !== want.y)
                report_mismatch($sformatf("point_y %0d, want %0d", got.y, want.y));
            if (got.z !== want.z)
                report_mismatch($sformatf("point_z %0d, want %0d", got.z, want.z));
            if (got.st !== want.st)
                report_mismatch($sformatf("status %b, want %b", got.st, want.st));
            if (got.fin !== want.fin)
                report_mismatch($sformatf("last %b, want %b", got.fin, want.fin));
        endtask
    endclass

    PointScoreboard points_due = new();

    cubic_bezier_segmenter_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .start_x(start_x), .start_y(start_y), .start_z(start_z),
        .target_x(target_x), .target_y(target_y), .target_z(target_z),
        .i_off(i_off), .j_off(j_off), .p_off(p_off), .q_off(q_off),
        .ij_words(ij_words), .chained(chained),
        .out_valid(out_valid), .out_stall(out_stall),
        .point_x(point_x), .point_y(point_y), .point_z(point_z),
        .status(status), .last(last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Offer one move, after a random gap while idle_on is set, and hold it until the block takes it.
    task automatic send_move(input move_t mv);
        int gap;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start_x <= mv.sx; start_y <= mv.sy; start_z <= mv.sz;
        target_x <= mv.tx; target_y <= mv.ty; target_z <= mv.tz;
        i_off <= mv.io; j_off <= mv.jo; p_off <= mv.po; q_off <= mv.qo;
        ij_words <= mv.words;
        chained <= mv.chained;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        points_due.note_move(mv);
    endtask

    // Drain everything in flight, then write the segment length.
    task automatic set_segment_length(input logic [SEG_W-1:0] value);
        in_valid <= 1'b0;
        do @(posedge clk); while (points_due.due.size() != 0);
        repeat (4) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        points_due.seg_len = value;
    endtask

    function automatic logic signed [COORD_W-1:0] near_off(input longint span);
        return 32'(longint'($urandom_range(0, 32'(2 * span))) - span);
    endfunction

    // Mostly well-formed moves whose legs stay within a few segment lengths;
    // a few wild ones cover every bit and saturate to the segment cap.
    function automatic move_t random_move(input longint span, input bit wild);
        move_t mv;
        int roll;
        mv.sx = $urandom; mv.sy = $urandom; mv.sz = $urandom; mv.tz = $urandom;
        if (wild)
        begin
            mv.tx = $urandom; mv.ty = $urandom;
            mv.io = $urandom; mv.jo = $urandom; mv.po = $urandom; mv.qo = $urandom;
        end
        else
        begin
            mv.tx = mv.sx + near_off(span);
            mv.ty = mv.sy + near_off(span);
            mv.io = near_off(span); mv.jo = near_off(span);
            mv.po = near_off(span); mv.qo = near_off(span);
        end
        roll = $urandom_range(0, 99);
        mv.chained = $urandom_range(0, 1);
        if (roll < 10)
        begin
            mv.words = $urandom_range(0, 2);
            if (mv.words == WORDS_NONE) mv.chained = 1'b0;
        end
        else if (roll < 45)
        begin
            mv.words = WORDS_NONE;
            mv.chained = 1'b1;
        end
        else
        begin
            mv.words = WORDS_BOTH;
        end
        return mv;
    endfunction

    function automatic move_t plain_move(input logic signed [31:0] s, t, io, jo, po, qo,
                                         input logic [1:0] w, input logic ch);
        move_t mv;
        mv = '{sx: s, sy: -s, sz: s, tx: t, ty: ~t, tz: t, io: io, jo: jo,
               po: po, qo: qo, words: w, chained: ch};
        return mv;
    endfunction

    // Stimulus: reset, directed corners, then random phases per segment length.
    initial
    begin
        logic [SEG_W-1:0] seg_plan[8];
        logic signed [31:0] one, big, tiny;
        longint span;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        one = 32'sd65536;
        big = 32'sh7FFFFFFF;
        tiny = 32'sh80000000;

        // Error cases: nothing given, only I, only J, chained with a lone word.
        send_move(plain_move(one, 3 * one, one, one, one, one, 2'b00, 1'b0));
        send_move(plain_move(one, 3 * one, one, one, one, one, 2'b01, 1'b0));
        send_move(plain_move(one, 3 * one, one, one, one, one, 2'b10, 1'b0));
        send_move(plain_move(one, 3 * one, one, one, one, one, 2'b01, 1'b1));
        send_move(plain_move(one, 3 * one, one, one, one, one, 2'b10, 1'b1));
        // Good move, then a chained one that mirrors its P/Q, then chained with I/J.
        send_move(plain_move(one, 4 * one, one, -one, 2 * one, -one, WORDS_BOTH, 1'b0));
        send_move(plain_move(4 * one, 7 * one, 0, 0, -one, one, WORDS_NONE, 1'b1));
        send_move(plain_move(0, 2 * one, -one, one, one, one, WORDS_BOTH, 1'b1));
        // Degenerate: the points nearly coincide (target Y is -1), only the target comes out.
        send_move(plain_move(0, 0, 0, 0, 0, 0, WORDS_BOTH, 1'b0));
        // Extremes: the segment count caps and coordinates saturate.
        send_move(plain_move(big, tiny, big, tiny, big, tiny, WORDS_BOTH, 1'b0));
        send_move(plain_move(tiny, big, tiny, big, tiny, big, WORDS_BOTH, 1'b1));
        send_move(plain_move(big, big, 0, 0, 0, 0, WORDS_NONE, 1'b1));

        seg_plan = '{31'd65536, 31'd1, 31'h7FFFFFFF, 31'($urandom_range(1, 1 << 20)),
                     31'd16, 31'($urandom_range(1, 32'h7FFFFFFF)), 31'd262144,
                     31'($urandom_range(1, 1000))};
        foreach (seg_plan[p])
        begin
            set_segment_length(seg_plan[p]);
            idle_on = ($urandom_range(0, 3) != 0);
            span = 2 * longint'(seg_plan[p]);
            if (span > (64'd1 << 30)) span = 64'd1 << 30;
            repeat (PHASE_MOVES)
            begin
                send_move(random_move(span, seg_plan[p] == 31'h7FFFFFFF
                                            || $urandom_range(0, 99) < 5));
            end
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (points_due.due.size() != 0);
        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && points_due.due.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Receiver: random hold-off before each transfer while idle_on is set, and
    // once a long hold so the block backs up and stalls its input while moves keep coming.
    initial
    begin
        int gap;
        int taken;
        point_t got;
        taken = 0;
        @(posedge rst_n);
        forever
        begin
            gap = idle_on ? $urandom_range(0, 7) : 0;
            if (taken == 100) gap = HOLD_CYCLES;
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            got = '{x: point_x, y: point_y, z: point_z, st: status, fin: last};
            points_due.check_point(got);
            taken++;
        end
    end

    // Watchdog: end the run if no transfer happens for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
                if (quiet >= IDLE_LIMIT)
                begin
                    $display("[FAIL] regression broken");
                    $finish;
                end
            end
        end
    end
endmodule
